>>> src/tsr_pkg.sv
// Shared types, widths, constants and the cosine table of the tilt-sense report controller.
package tsr_pkg;

  localparam int unsigned ACC_W       = 12;
  localparam int unsigned BATT_W      = 8;
  localparam int unsigned JIT_W       = 2;
  localparam int unsigned ANGLE_W     = 7;
  localparam int unsigned SQ_W        = 2 * ACC_W;
  localparam int unsigned MAG_W       = 24;
  localparam int unsigned PER_W       = 16;
  localparam int unsigned TT_W        = 8;
  localparam int unsigned DB_W        = 4;
  localparam int unsigned ATHR_W      = 8;
  localparam int unsigned MTHR_W      = 12;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam int unsigned ANGLE_STEPS = 19;
  localparam int unsigned STEP_W      = 5;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 7'd90;

  // cos(5 deg * i) in milli-g
  localparam logic [ACC_W-1:0] COS_TABLE [ANGLE_STEPS] = '{
    12'd1000, 12'd996, 12'd984, 12'd965, 12'd939, 12'd906, 12'd866, 12'd819, 12'd766,
    12'd707,  12'd642, 12'd573, 12'd500, 12'd422, 12'd342, 12'd258, 12'd173, 12'd87,
    12'd0
  };

  localparam logic [ATHR_W-1:0] ANGLE_THR_RST  = 8'd30;
  localparam logic [MTHR_W-1:0] MOTION_THR_RST = 12'd1200;
  localparam logic [TT_W-1:0]   TILT_LIMIT_RST = 8'd10;
  localparam logic [DB_W-1:0]   DEBOUNCE_RST   = 4'd3;
  localparam logic [PER_W-1:0]  SENSE_PER_RST  = 16'd1800;
  localparam logic [PER_W-1:0]  TILT_PER_RST   = 16'd5;
  localparam logic [PER_W-1:0]  MAINT_PER_RST  = 16'd1800;

  typedef enum logic [1:0] {
    MODE_SENSE    = 2'd0,
    MODE_TILT     = 2'd1,
    MODE_MAINTAIN = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ALIVE    = 2'd0,
    KIND_SENSE    = 2'd1,
    KIND_MAINTAIN = 2'd2
  } kind_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ANGLE_THR  = 3'd0,
    REG_MOTION_THR = 3'd1,
    REG_TILT_LIMIT = 3'd2,
    REG_DEBOUNCE   = 3'd3,
    REG_SENSE_PER  = 3'd4,
    REG_TILT_PER   = 3'd5,
    REG_MAINT_PER  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [ATHR_W-1:0] angle_thr;
    logic [MTHR_W-1:0] motion_thr;
    logic [TT_W-1:0]   tilt_limit;
    logic [DB_W-1:0]   debounce;
    logic [PER_W-1:0]  sense_per;
    logic [PER_W-1:0]  tilt_per;
    logic [PER_W-1:0]  maint_per;
  } cfg_t;

  typedef struct packed {
    logic [SQ_W-1:0]    sq_x;
    logic [SQ_W-1:0]    sq_y;
    logic [SQ_W-1:0]    sq_z;
    logic [ANGLE_W-1:0] angle;
    logic               angle_ok;
    logic [BATT_W-1:0]  battery;
    logic [JIT_W-1:0]   jitter;
  } feat_t;

  typedef struct packed {
    logic               send;
    kind_e              kind;
    logic [ANGLE_W-1:0] angle;
    logic [BATT_W-1:0]  battery;
    mode_e              mode;
    logic               tilted;
  } res_t;

endpackage

>>> src/tilt_sense_report_controller_top.sv
// Top level of the tilt-sense report controller: input register, register bank and stages.
//
//  channel   direction  transfer when                  payload
//  s_axis    in         s_axis_tvalid & s_axis_tready  one sensor tick (tdata)
//  m_axis    out        m_axis_tvalid & m_axis_tready  one result per tick (tdata, tuser)
//  cfg       in         cfg_valid_i & cfg_ready_o      register index and value
//
// One tick enters per cycle unless the output is stalled; its result passes through the input
// register, the feature register with the three squarers and the result register.
// Reset clears all valid flags, the mode state and the interval counter and loads
// the register defaults; no clearing pass is needed.
// A stalled output holds the whole pipeline; s_axis_tready drops only while a
// result waits and m_axis_tready is low. The config port is always ready.
module tilt_sense_report_controller_top import tsr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // accel_x[11:0], accel_y[23:12], accel_z[35:24], battery_level[43:36],
  // jitter[45:44], zero fill [47:46]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // send_report[0], tilt_angle[7:1], report_battery[15:8], node_mode[17:16],
  // is_tilted[18], zero fill [23:19]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // report_kind[1:0]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic                    adv;
  logic                    in_valid_q;
  logic [IN_TDATA_W-1:0]   in_data_q;
  cfg_t                    cfg_q;
  logic                    feat_valid;
  feat_t                   feat;
  logic [MAG_W-1:0]        thr_sq;
  logic                    res_valid;
  res_t                    res;

  // Advance everything together unless a finished result is still held
  assign adv           = !res_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  // Register bank: writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_thr  <= ANGLE_THR_RST;
      cfg_q.motion_thr <= MOTION_THR_RST;
      cfg_q.tilt_limit <= TILT_LIMIT_RST;
      cfg_q.debounce   <= DEBOUNCE_RST;
      cfg_q.sense_per  <= SENSE_PER_RST;
      cfg_q.tilt_per   <= TILT_PER_RST;
      cfg_q.maint_per  <= MAINT_PER_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_ANGLE_THR:  cfg_q.angle_thr  <= cfg_data_i[ATHR_W-1:0];
        REG_MOTION_THR: cfg_q.motion_thr <= cfg_data_i[MTHR_W-1:0];
        REG_TILT_LIMIT: cfg_q.tilt_limit <= cfg_data_i[TT_W-1:0];
        REG_DEBOUNCE:   cfg_q.debounce   <= cfg_data_i[DB_W-1:0];
        REG_SENSE_PER:  cfg_q.sense_per  <= cfg_data_i[PER_W-1:0];
        REG_TILT_PER:   cfg_q.tilt_per   <= cfg_data_i[PER_W-1:0];
        REG_MAINT_PER:  cfg_q.maint_per  <= cfg_data_i[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
  end

  tsr_feature u_feature (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .in_valid_i   (in_valid_q),
    .accel_x_i    (in_data_q[11:0]),
    .accel_y_i    (in_data_q[23:12]),
    .accel_z_i    (in_data_q[35:24]),
    .battery_i    (in_data_q[43:36]),
    .jitter_i     (in_data_q[45:44]),
    .cfg_i        (cfg_q),
    .feat_valid_o (feat_valid),
    .feat_o       (feat),
    .thr_sq_o     (thr_sq)
  );

  tsr_mode u_mode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .feat_valid_i (feat_valid),
    .feat_i       (feat),
    .thr_sq_i     (thr_sq),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Pack the result; the kind travels on tuser
  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res.kind;
  assign m_axis_tdata  = {5'd0, res.tilted, res.mode, res.battery, res.angle, res.send};

endmodule

>>> src/tsr_feature.sv
// Feature stage: absolute values, squares, tilt angle lookup and angle threshold test.
module tsr_feature import tsr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    in_valid_i,
  input  logic signed [ACC_W-1:0] accel_x_i,
  input  logic signed [ACC_W-1:0] accel_y_i,
  input  logic signed [ACC_W-1:0] accel_z_i,
  input  logic [BATT_W-1:0]       battery_i,
  input  logic [JIT_W-1:0]        jitter_i,
  input  cfg_t                    cfg_i,
  output logic                    feat_valid_o,
  output feat_t                   feat_o,
  output logic [MAG_W-1:0]        thr_sq_o
);

  logic [ACC_W-1:0]   abs_x, abs_y, abs_z;
  logic [STEP_W-1:0]  step;
  logic [ANGLE_W-1:0] angle;
  logic               valid_q;
  feat_t              feat_q;
  logic [MAG_W-1:0]   thr_sq_q;

  // Magnitude of -2048 is 2048, which still fits unsigned
  assign abs_x = accel_x_i[ACC_W-1] ? ACC_W'(-accel_x_i) : accel_x_i;
  assign abs_y = accel_y_i[ACC_W-1] ? ACC_W'(-accel_y_i) : accel_y_i;
  assign abs_z = accel_z_i[ACC_W-1] ? ACC_W'(-accel_z_i) : accel_z_i;

  // Table falls monotonically: the step is the count of entries above |y|
  always_comb begin
    step = '0;
    for (int i = 0; i < ANGLE_STEPS - 1; i++) begin
      if (COS_TABLE[i] > abs_y) begin
        step = step + STEP_W'(1);
      end
    end
    angle = ANGLE_W'({step, 2'b00}) + ANGLE_W'(step);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_sq_q <= MAG_W'(cfg_i.motion_thr) * MAG_W'(cfg_i.motion_thr);
    if (adv_i && in_valid_i) begin
      feat_q.sq_x     <= SQ_W'(abs_x) * SQ_W'(abs_x);
      feat_q.sq_y     <= SQ_W'(abs_y) * SQ_W'(abs_y);
      feat_q.sq_z     <= SQ_W'(abs_z) * SQ_W'(abs_z);
      feat_q.angle    <= angle;
      feat_q.angle_ok <= {1'b0, angle} >= cfg_i.angle_thr;
      feat_q.battery  <= battery_i;
      feat_q.jitter   <= jitter_i;
    end
  end

  assign feat_valid_o = valid_q;
  assign feat_o       = feat_q;
  assign thr_sq_o     = thr_sq_q;

endmodule

>>> src/tsr_mode.sv
// Mode stage: tilt decision, sense/tilt/maintain state machine, report interval and result register.
module tsr_mode import tsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             feat_valid_i,
  input  feat_t            feat_i,
  input  logic [MAG_W-1:0] thr_sq_i,
  input  cfg_t             cfg_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  mode_e             mode_q, mode_d;
  kind_e             kind_q, kind_d;
  logic [TT_W-1:0]   ticks_q, ticks_d;
  logic [DB_W-1:0]   sdb_q, sdb_d, tdb_q, tdb_d, mdb_q, mdb_d;
  logic [PER_W-1:0]  icnt_q, icnt_d;
  logic [PER_W-1:0]  reload_q [3];
  logic [PER_W-1:0]  reload_d [3];
  logic [MAG_W-1:0]  mag;
  logic              tilted;
  logic [PER_W-1:0]  reload_cur, period;
  logic [PER_W:0]    psum;
  logic              send;
  logic              valid_q;
  res_t              res_q;

  assign mag    = MAG_W'(feat_i.sq_x) + MAG_W'(feat_i.sq_y) + MAG_W'(feat_i.sq_z);
  assign tilted = feat_i.angle_ok && (mag <= thr_sq_i);

  always_comb begin
    mode_d   = mode_q;
    kind_d   = kind_q;
    ticks_d  = ticks_q;
    sdb_d    = sdb_q;
    tdb_d    = tdb_q;
    mdb_d    = mdb_q;
    icnt_d   = icnt_q;
    reload_d = reload_q;
    send     = 1'b0;

    case (mode_q)
      MODE_SENSE: begin
        if (tilted) begin
          if (sdb_q < cfg_i.debounce) begin
            sdb_d = sdb_q + DB_W'(1);
          end else begin
            sdb_d  = '0;
            mode_d = MODE_TILT;
            kind_d = KIND_SENSE;
          end
        end else begin
          kind_d  = KIND_ALIVE;
          ticks_d = '0;
        end
      end
      MODE_TILT: begin
        if (tilted) begin
          kind_d = KIND_SENSE;
          if (ticks_q != '1) begin
            ticks_d = ticks_q + TT_W'(1);
          end
        end else if (tdb_q < cfg_i.debounce) begin
          tdb_d = tdb_q + DB_W'(1);
        end else begin
          tdb_d   = '0;
          mode_d  = MODE_SENSE;
          ticks_d = '0;
        end
        if (ticks_d >= cfg_i.tilt_limit) begin
          mode_d = MODE_MAINTAIN;
        end
      end
      MODE_MAINTAIN: begin
        if (tilted) begin
          kind_d = KIND_MAINTAIN;
        end else if (mdb_q < cfg_i.debounce) begin
          mdb_d = mdb_q + DB_W'(1);
        end else begin
          mdb_d   = '0;
          kind_d  = KIND_ALIVE;
          mode_d  = MODE_SENSE;
          ticks_d = '0;
        end
      end
      default: ;
    endcase

    // Interval runs on the mode after this tick
    case (mode_d)
      MODE_TILT: begin
        reload_cur = reload_q[1];
        period     = cfg_i.tilt_per;
      end
      MODE_MAINTAIN: begin
        reload_cur = reload_q[2];
        period     = cfg_i.maint_per;
      end
      default: begin
        reload_cur = reload_q[0];
        period     = cfg_i.sense_per;
      end
    endcase

    psum = {1'b0, period} + (PER_W + 1)'(feat_i.jitter);

    if (icnt_q < reload_cur) begin
      icnt_d = icnt_q + PER_W'(1);
    end else begin
      send   = 1'b1;
      icnt_d = '0;
      case (mode_d)
        MODE_TILT:     reload_d[1] = psum[PER_W] ? '1 : psum[PER_W-1:0];
        MODE_MAINTAIN: reload_d[2] = psum[PER_W] ? '1 : psum[PER_W-1:0];
        default:       reload_d[0] = psum[PER_W] ? '1 : psum[PER_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SENSE;
      kind_q      <= KIND_ALIVE;
      ticks_q     <= '0;
      sdb_q       <= '0;
      tdb_q       <= '0;
      mdb_q       <= '0;
      icnt_q      <= '0;
      reload_q[0] <= SENSE_PER_RST;
      reload_q[1] <= TILT_PER_RST;
      reload_q[2] <= MAINT_PER_RST;
      valid_q     <= 1'b0;
    end else if (adv_i) begin
      valid_q <= feat_valid_i;
      if (feat_valid_i) begin
        mode_q   <= mode_d;
        kind_q   <= kind_d;
        ticks_q  <= ticks_d;
        sdb_q    <= sdb_d;
        tdb_q    <= tdb_d;
        mdb_q    <= mdb_d;
        icnt_q   <= icnt_d;
        reload_q <= reload_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && feat_valid_i) begin
      res_q.send    <= send;
      res_q.kind    <= kind_d;
      res_q.angle   <= feat_i.angle;
      res_q.battery <= send ? feat_i.battery : '0;
      res_q.mode    <= mode_d;
      res_q.tilted  <= tilted;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> src/tsr_checker.sv
// Port-level checker for the tilt-sense report controller, bound to the top level.
module tsr_checker import tsr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Battery byte only rides on a report
  a_batt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[15:8] == 8'd0)
    else $error("battery byte without report");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] <= ANGLE_MAX)
    else $error("tilt angle out of range");

  // Tilt state is entered with a sense packet and only ever refreshes it
  a_tilt_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17:16] == MODE_TILT |-> m_axis_tuser == KIND_SENSE)
    else $error("tilt state with wrong packet kind");

endmodule

bind tilt_sense_report_controller_top tsr_checker u_tsr_checker (.*);
